// ----- src/acl_pkg.sv -----
// Shared package for the access control table: status codes, entry layout,
// memory command and the default table size. Depends on nothing.
package acl_pkg;

   localparam int unsigned DEFAULT_TABLE_ENTRIES = 32;

   localparam int unsigned USER_W = 8;
   localparam int unsigned RESOURCE_W = 8;
   localparam int unsigned PERM_W = 3;
   localparam int unsigned STATUS_W = 3;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ADDED   = 3'd0,
      STATUS_FULL    = 3'd1,
      STATUS_GRANTED = 3'd2,
      STATUS_DENIED  = 3'd3,
      STATUS_NOENTRY = 3'd4
   } status_type;

   typedef struct packed {
      logic [USER_W-1:0]     user;
      logic [RESOURCE_W-1:0] resource;
      logic [PERM_W-1:0]     perm;
   } entry_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

endpackage

// ----- src/acl_table_access_check_top.sv -----
// Access control table top level: an add writes its entry, if there is room,
// on acceptance and its status strobes in the cycle after acceptance. A check
// reads one stored entry per cycle from the entry memory, holds busy while it
// scans and strobes its status in the first cycle with busy low. Synchronous
// reset empties the table; results cannot be stalled. Depends on acl_pkg,
// acl_mem, acl_ctrl.
module acl_table_access_check_top
   import acl_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_mode,
   input  logic [USER_W-1:0]     req_user_id,
   input  logic [RESOURCE_W-1:0] req_resource_id,
   input  logic [PERM_W-1:0]     req_permission_bits,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status
);

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   mem_cmd_type      mem_cmd;
   logic [IDX_W-1:0] mem_addr;
   entry_type        mem_wr_entry;
   entry_type        mem_rd_entry;

   acl_ctrl #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_user_id        (req_user_id),
      .req_resource_id    (req_resource_id),
      .req_permission_bits(req_permission_bits),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .mem_cmd            (mem_cmd),
      .mem_addr           (mem_addr),
      .mem_wr_entry       (mem_wr_entry),
      .mem_rd_entry       (mem_rd_entry)
   );

   acl_mem #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .addr    (mem_addr),
      .wr_entry(mem_wr_entry),
      .rd_entry(mem_rd_entry)
   );

endmodule

// ----- src/acl_mem.sv -----
// Entry store of the access control table: one write port and one read port
// that share one address, with registered read data. Depends on acl_pkg.
module acl_mem
   import acl_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES,
   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic             clock,
   input  mem_cmd_type      cmd,
   input  logic [IDX_W-1:0] addr,
   input  entry_type        wr_entry,
   output entry_type        rd_entry
);

   entry_type mem_ff [TABLE_ENTRIES];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[addr] <= wr_entry;
      end
      if (cmd.rd_en) begin
         rd_entry_ff <= mem_ff[addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ----- src/acl_ctrl.sv -----
// Sequencer of the access control table: appends entries, scans the store
// in insertion order for a check and produces the status. Depends on acl_pkg.
module acl_ctrl
   import acl_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES,
   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
   localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_mode,
   input  logic [USER_W-1:0]     req_user_id,
   input  logic [RESOURCE_W-1:0] req_resource_id,
   input  logic [PERM_W-1:0]     req_permission_bits,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output mem_cmd_type           mem_cmd,
   output logic [IDX_W-1:0]      mem_addr,
   output entry_type             mem_wr_entry,
   input  entry_type             mem_rd_entry
);

   typedef enum logic [0:0] {
      S_IDLE,
      S_SCAN
   } state_type;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic [CNT_W-1:0] pend_idx_ff, pend_idx_in;
   logic             pending_ff, pending_in;
   entry_type        key_ff, key_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic accept;
   logic hit;
   logic last;

   assign accept = start && (state_ff == S_IDLE);
   assign hit = (mem_rd_entry.user == key_ff.user)
             && (mem_rd_entry.resource == key_ff.resource);
   assign last = (pend_idx_ff + CNT_W'(1)) == fill_ff;

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      issue_in      = issue_ff;
      pend_idx_in   = pend_idx_ff;
      pending_in    = 1'b0;
      key_in        = key_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      mem_cmd       = '0;
      mem_addr      = issue_ff[IDX_W-1:0];
      mem_wr_entry  = '{user: req_user_id, resource: req_resource_id,
                        perm: req_permission_bits};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in = mem_wr_entry;
               if (!req_mode) begin
                  rsp_valid_in = 1'b1;
                  if (fill_ff < FULL_COUNT) begin
                     mem_cmd.wr_en = 1'b1;
                     mem_addr      = fill_ff[IDX_W-1:0];
                     fill_in       = fill_ff + CNT_W'(1);
                     rsp_status_in = STATUS_ADDED;
                  end else begin
                     rsp_status_in = STATUS_FULL;
                  end
               end else if (fill_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NOENTRY;
               end else begin
                  mem_cmd.rd_en = 1'b1;
                  mem_addr      = '0;
                  pending_in    = 1'b1;
                  pend_idx_in   = '0;
                  issue_in      = CNT_W'(1);
                  state_in      = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (pending_ff && hit) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ((mem_rd_entry.perm & key_ff.perm) == key_ff.perm)
                             ? STATUS_GRANTED : STATUS_DENIED;
               state_in      = S_IDLE;
            end else if (pending_ff && last) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NOENTRY;
               state_in      = S_IDLE;
            end else if (issue_ff < fill_ff) begin
               mem_cmd.rd_en = 1'b1;
               pending_in    = 1'b1;
               pend_idx_in   = issue_ff;
               issue_in      = issue_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issue_ff      <= issue_in;
      pend_idx_ff   <= pend_idx_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for acl_table_access_check_top: directed table rows, then random
// add and check transactions scored against an in-bench shadow of the access table.
// Depends on acl_pkg and the acl_table_access_check_top RTL.
module testbench;
   import acl_pkg::*;

   localparam int unsigned TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES;
   localparam int unsigned SHADOW_IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned DIRECTED_ROWS = 20;
   localparam int unsigned ROW_IDX_W = $clog2(DIRECTED_ROWS);
   localparam int unsigned POOL_SIZE = 4;
   localparam int unsigned POOL_IDX_W = $clog2(POOL_SIZE);
   localparam int unsigned RANDOM_ITEMS = 1930;
   localparam int unsigned QUIET_ITEMS = 200;
   localparam int unsigned DRAIN_CYCLES = TABLE_ENTRIES + 4;
   localparam int unsigned RUN_LIMIT = 12 * 600000;

   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_CHECK = 1'b1;

   typedef struct packed {
      logic                  mode;
      logic [USER_W-1:0]     user;
      logic [RESOURCE_W-1:0] resource;
      logic [PERM_W-1:0]     perm;
      logic                  typed;
      status_type            status;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_mode = MODE_ADD;
   logic [USER_W-1:0]     req_user_id = '0;
   logic [RESOURCE_W-1:0] req_resource_id = '0;
   logic [PERM_W-1:0]     req_permission_bits = '0;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;

   entry_type             shadow_entries [TABLE_ENTRIES];
   int unsigned           shadow_count = 0;
   status_type            expected_status [$];
   int unsigned           error_count = 0;
   directed_row_type      directed_rows [DIRECTED_ROWS];
   logic [USER_W-1:0]     user_pool [POOL_SIZE];
   logic [RESOURCE_W-1:0] resource_pool [POOL_SIZE];

   acl_table_access_check_top #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_user_id(req_user_id),
      .req_resource_id(req_resource_id),
      .req_permission_bits(req_permission_bits),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status)
   );

   always #6 clock = ~clock;

   function automatic status_type acl_lookup(input logic mode,
                                             input logic [USER_W-1:0] user,
                                             input logic [RESOURCE_W-1:0] resource,
                                             input logic [PERM_W-1:0] perm);
      status_type outcome;
      logic       found;
      int         i;
      outcome = STATUS_NOENTRY;
      found = 1'b0;
      if (mode == MODE_ADD) begin
         if (shadow_count < TABLE_ENTRIES) begin
            shadow_entries[SHADOW_IDX_W'(shadow_count)].user = user;
            shadow_entries[SHADOW_IDX_W'(shadow_count)].resource = resource;
            shadow_entries[SHADOW_IDX_W'(shadow_count)].perm = perm;
            shadow_count++;
            outcome = STATUS_ADDED;
         end else begin
            outcome = STATUS_FULL;
         end
      end else begin
         for (i = 0; i < shadow_count && !found; i++) begin
            if (shadow_entries[SHADOW_IDX_W'(i)].user == user
                && shadow_entries[SHADOW_IDX_W'(i)].resource == resource) begin
               found = 1'b1;
               outcome = ((shadow_entries[SHADOW_IDX_W'(i)].perm & perm) == perm)
                       ? STATUS_GRANTED : STATUS_DENIED;
            end
         end
      end
      return outcome;
   endfunction

   task automatic issue(input logic mode, input logic [USER_W-1:0] user,
                        input logic [RESOURCE_W-1:0] resource, input logic [PERM_W-1:0] perm,
                        input logic typed, input status_type typed_status, input bit may_idle);
      status_type predicted;
      if (may_idle && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         req_mode <= 1'($urandom);
         req_user_id <= USER_W'($urandom);
         req_resource_id <= RESOURCE_W'($urandom);
         req_permission_bits <= PERM_W'($urandom);
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_user_id <= user;
      req_resource_id <= resource;
      req_permission_bits <= perm;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = acl_lookup(mode, user, resource, perm);
      expected_status.push_back(typed ? typed_status : predicted);
   endtask

   always @(posedge clock) begin : check_results
      status_type wanted;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_status.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual status %0d",
                     $time, rsp_status);
            error_count++;
         end else begin
            wanted = expected_status.pop_front();
            if (rsp_status !== wanted) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, wanted, rsp_status);
               error_count++;
            end
         end
      end
   end

   initial begin : timeout
      #(RUN_LIMIT);
      $display("acl_table_access_check_top verification failed");
      $finish;
   end

   initial begin : stimulus
      int                    n;
      int                    pick;
      int                    slot;
      int                    add_weight;
      logic                  mode;
      logic [USER_W-1:0]     user;
      logic [RESOURCE_W-1:0] resource;
      logic [PERM_W-1:0]     perm;

      directed_rows = '{
         '{MODE_CHECK, 8'h00, 8'h00, 3'b000, 1'b1, STATUS_NOENTRY},
         '{MODE_CHECK, 8'hff, 8'hff, 3'b111, 1'b1, STATUS_NOENTRY},
         '{MODE_ADD,   8'h00, 8'h00, 3'b000, 1'b1, STATUS_ADDED},
         '{MODE_ADD,   8'hff, 8'hff, 3'b111, 1'b1, STATUS_ADDED},
         '{MODE_ADD,   8'h12, 8'h34, 3'b101, 1'b1, STATUS_ADDED},
         '{MODE_ADD,   8'h12, 8'h34, 3'b111, 1'b1, STATUS_ADDED},
         '{MODE_CHECK, 8'h00, 8'h00, 3'b000, 1'b1, STATUS_GRANTED},
         '{MODE_CHECK, 8'h00, 8'h00, 3'b001, 1'b1, STATUS_DENIED},
         '{MODE_CHECK, 8'hff, 8'hff, 3'b111, 1'b1, STATUS_GRANTED},
         '{MODE_CHECK, 8'h12, 8'h34, 3'b010, 1'b0, STATUS_DENIED},
         '{MODE_CHECK, 8'h12, 8'h34, 3'b101, 1'b0, STATUS_GRANTED},
         '{MODE_CHECK, 8'h12, 8'h35, 3'b000, 1'b0, STATUS_NOENTRY},
         '{MODE_CHECK, 8'h13, 8'h34, 3'b000, 1'b0, STATUS_NOENTRY},
         '{MODE_CHECK, 8'hff, 8'h00, 3'b000, 1'b0, STATUS_NOENTRY},
         '{MODE_ADD,   8'haa, 8'h55, 3'b001, 1'b1, STATUS_ADDED},
         '{MODE_ADD,   8'h55, 8'haa, 3'b110, 1'b1, STATUS_ADDED},
         '{MODE_CHECK, 8'haa, 8'h55, 3'b001, 1'b0, STATUS_GRANTED},
         '{MODE_CHECK, 8'haa, 8'h55, 3'b100, 1'b0, STATUS_DENIED},
         '{MODE_CHECK, 8'h55, 8'haa, 3'b110, 1'b0, STATUS_GRANTED},
         '{MODE_CHECK, 8'h55, 8'haa, 3'b011, 1'b0, STATUS_DENIED}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         issue(directed_rows[ROW_IDX_W'(n)].mode, directed_rows[ROW_IDX_W'(n)].user,
               directed_rows[ROW_IDX_W'(n)].resource, directed_rows[ROW_IDX_W'(n)].perm,
               directed_rows[ROW_IDX_W'(n)].typed, directed_rows[ROW_IDX_W'(n)].status,
               1'b1);
      end

      // A small pool of ids makes repeated and near-miss user/resource pairs common.
      for (n = 0; n < POOL_SIZE; n++) begin
         user_pool[POOL_IDX_W'(n)] = USER_W'($urandom);
         resource_pool[POOL_IDX_W'(n)] = RESOURCE_W'($urandom);
      end

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         add_weight = (shadow_count < TABLE_ENTRIES) ? 35 : 8;
         perm = PERM_W'($urandom);
         if (pick < add_weight) begin
            mode = MODE_ADD;
            if ($urandom_range(0, 9) < 6) begin
               user = user_pool[POOL_IDX_W'($urandom_range(0, POOL_SIZE - 1))];
               resource = resource_pool[POOL_IDX_W'($urandom_range(0, POOL_SIZE - 1))];
            end else begin
               user = USER_W'($urandom);
               resource = RESOURCE_W'($urandom);
            end
         end else begin
            mode = MODE_CHECK;
            pick = $urandom_range(0, 9);
            if (pick < 7 && shadow_count > 0) begin
               slot = $urandom_range(0, shadow_count - 1);
               user = shadow_entries[SHADOW_IDX_W'(slot)].user;
               resource = shadow_entries[SHADOW_IDX_W'(slot)].resource;
            end else if (pick < 9) begin
               user = user_pool[POOL_IDX_W'($urandom_range(0, POOL_SIZE - 1))];
               resource = resource_pool[POOL_IDX_W'($urandom_range(0, POOL_SIZE - 1))];
            end else begin
               user = USER_W'($urandom);
               resource = RESOURCE_W'($urandom);
            end
         end
         issue(mode, user, resource, perm, 1'b0, STATUS_ADDED,
               n < RANDOM_ITEMS - QUIET_ITEMS);
      end
      start <= 1'b0;

      while (expected_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_status.size() == 0) begin
         $display("acl_table_access_check_top verification clean");
      end else begin
         $display("acl_table_access_check_top verification failed");
      end
      $finish;
   end

endmodule
